FILE: hw/rtl/pfq_pkg.sv
// ----------------------------------------------------------------------------
// pfq_pkg: shared definitions for the timestamp queue
// Register indexes, reset values, field widths and the timestamp order key.
// ----------------------------------------------------------------------------
`default_nettype none

package pfq_pkg;

  // Queue depth default
  localparam int DEPTH_DEF = 16;

  // Field widths
  localparam int TAG_W   = 16;
  localparam int PTS_W   = 63;
  localparam int CAP_W   = 5;
  localparam int TOL_W   = 32;
  localparam int DROP_W  = 4;
  localparam int CFG_AW  = 1;
  localparam int CFG_DW  = 32;
  localparam int S_DW    = 144;
  localparam int M_DW    = 88;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_AW-1:0] REG_DROP_TOL = 1'd1;

  // Register reset values
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [TOL_W-1:0] TOL_RESET = 32'd1000000;

  // Saturation limit of the drop counter
  localparam logic [DROP_W-1:0] DROP_MAX = 4'd15;

  // Command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // One stored frame
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [PTS_W-1:0] pts;
  } entry_t;

  // Order-preserving unsigned key of a signed timestamp: flip the sign bit
  function automatic logic [PTS_W-1:0] pts_key(input logic [PTS_W-1:0] raw);
    pts_key = {~raw[PTS_W-1], raw[PTS_W-2:0]};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pts_frame_queue_with_drop_unit.sv
// ----------------------------------------------------------------------------
// pts_frame_queue_with_drop_unit: timestamp-ordered frame queue
// Sorted ring buffer in a memory; one shared add-and-compare unit walks it
// to insert frames in order and to pop due frames, dropping late ones.
// ----------------------------------------------------------------------------
// Sequence: an enqueue walks down from the back, moving each entry with a
// later timestamp up one slot, and writes the frame behind the first entry
// not later, or at the front; a refused enqueue or a dequeue on an empty
// queue goes straight to the result. A dequeue examines entries from the
// front, dropping late ones. A busy result stream adds its stall.
// Throughput: one request at a time, set by one memory read per compare step.
// Reset: synchronous; the queue empties, capacity returns to 16 and the
// drop tolerance to 1000000. Memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_frame_queue_with_drop_unit
  import pfq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration write port
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  // request stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata from bit 0: frame_tag[16], frame_pts[63], now_time[63], zero pad[2]
  input  wire logic [S_DW-1:0]   s_axis_tdata,
  // tuser: cmd[1]
  input  wire logic              s_axis_tuser,
  // result stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // tdata from bit 0: accepted[1], got_frame[1], out_tag[16], out_pts[63],
  // dropped_count[4], zero pad[3]
  output logic [M_DW-1:0]        m_axis_tdata
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int KW   = (CW > DROP_W) ? CW : DROP_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ENQ_RD  = 3'd1;
  localparam logic [2:0] ST_ENQ_CMP = 3'd2;
  localparam logic [2:0] ST_DEQ_RD  = 3'd3;
  localparam logic [2:0] ST_DEQ_CMP = 3'd4;
  localparam logic [2:0] ST_DEQ_POP = 3'd5;
  localparam logic [2:0] ST_DONE    = 3'd6;

  logic [2:0]       state;
  logic [CAP_W-1:0] capacity;
  logic [TOL_W-1:0] drop_tol;
  logic [CW-1:0]    count;
  logic [AW-1:0]    head;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    keep;
  logic [PTS_W-1:0] opnd;
  logic [TAG_W-1:0] new_tag;

  // Result register
  logic              res_acc;
  logic              res_got;
  logic [TAG_W-1:0]  res_tag;
  logic [PTS_W-1:0]  res_pts;
  logic [DROP_W-1:0] res_drop;

  // Entry memory
  entry_t        mem [DEPTH];
  entry_t        rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  // Request fields
  logic [TAG_W-1:0] in_tag;
  logic [PTS_W-1:0] in_pts;
  logic [PTS_W-1:0] in_now;

  assign in_tag = s_axis_tdata[TAG_W-1:0];
  assign in_pts = s_axis_tdata[TAG_W+PTS_W-1:TAG_W];
  assign in_now = s_axis_tdata[TAG_W+2*PTS_W-1:TAG_W+PTS_W];

  assign s_axis_tready = (state == ST_IDLE);

  // Map a position in timestamp order to a memory slot
  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] hd,
                                            input logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = (CW+1)'(hd) + (CW+1)'(idx);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    to_phys = AW'(sum);
  endfunction

  // Shared add-and-compare unit: key(entry) + addend <= key(operand)
  logic [TOL_W-1:0] cmp_add;
  logic [PTS_W:0]   cmp_lhs;
  logic [PTS_W:0]   cmp_rhs;
  logic             cmp_le;

  always_comb begin
    cmp_add = ((state == ST_DEQ_CMP) && (pos != '0)) ? drop_tol : '0;
    cmp_lhs = {1'b0, pts_key(rd_data.pts)} + (PTS_W+1)'(cmp_add);
    cmp_rhs = {1'b0, pts_key(opnd)};
    cmp_le  = (cmp_lhs <= cmp_rhs);
  end

  // Queue full against capacity and depth
  logic full;
  assign full = (CMPW'(count) >= CMPW'(capacity)) || (count >= CW'(DEPTH));

  // Saturated drop count of the kept position
  logic [KW-1:0]     keep_ext;
  logic [DROP_W-1:0] drop_sat;
  always_comb begin
    keep_ext = KW'(keep);
    drop_sat = (keep_ext > KW'(DROP_MAX)) ? DROP_MAX : keep_ext[DROP_W-1:0];
  end

  // Pop bookkeeping
  logic [CW:0]   removed;
  logic [CW:0]   head_sum;
  logic [AW-1:0] head_next;
  always_comb begin
    removed  = (CW+1)'(keep) + (CW+1)'(1);
    head_sum = (CW+1)'(head) + removed;
    if (head_sum >= (CW+1)'(DEPTH)) begin
      head_sum = head_sum - (CW+1)'(DEPTH);
    end
    head_next = AW'(head_sum);
  end

  // Memory read and write addressing
  always_comb begin
    rd_addr = to_phys(head, pos);
    wr_en   = 1'b0;
    wr_addr = to_phys(head, pos);
    wr_data = '{tag: new_tag, pts: opnd};
    if (state == ST_ENQ_RD) begin
      rd_addr = to_phys(head, pos - CW'(1));
      wr_en   = (pos == '0);
    end else if (state == ST_ENQ_CMP) begin
      wr_en = 1'b1;
      if (!cmp_le) begin
        wr_data = rd_data;
      end
    end
  end

  // Memory port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      drop_tol <= TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CAPACITY: capacity <= cfg_wdata[CAP_W-1:0];
        REG_DROP_TOL: drop_tol <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      head          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // release the result once taken, unless a new one takes its place
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            res_acc  <= 1'b0;
            res_got  <= 1'b0;
            res_tag  <= '0;
            res_pts  <= '0;
            res_drop <= '0;
            new_tag  <= in_tag;
            if (s_axis_tuser == CMD_ENQ) begin
              opnd <= in_pts;
              pos  <= count;
              state <= full ? ST_DONE : ST_ENQ_RD;
            end else begin
              opnd <= in_now;
              pos  <= '0;
              keep <= '0;
              state <= (count == '0) ? ST_DONE : ST_DEQ_RD;
            end
          end
        end
        ST_ENQ_RD: begin
          // place at the front once every entry has moved up
          if (pos == '0) begin
            count   <= count + CW'(1);
            res_acc <= 1'b1;
            state   <= ST_DONE;
          end else begin
            state <= ST_ENQ_CMP;
          end
        end
        ST_ENQ_CMP: begin
          // move a later entry up, or drop the new frame in behind it
          if (!cmp_le) begin
            pos   <= pos - CW'(1);
            state <= ST_ENQ_RD;
          end else begin
            count   <= count + CW'(1);
            res_acc <= 1'b1;
            state   <= ST_DONE;
          end
        end
        ST_DEQ_RD: begin
          state <= ST_DEQ_CMP;
        end
        ST_DEQ_CMP: begin
          if (pos == '0) begin
            // earliest frame must be due
            if (!cmp_le) begin
              state <= ST_DONE;
            end else begin
              res_got <= 1'b1;
              res_tag <= rd_data.tag;
              res_pts <= rd_data.pts;
              keep    <= '0;
              if (count > CW'(1)) begin
                pos   <= CW'(1);
                state <= ST_DEQ_RD;
              end else begin
                state <= ST_DEQ_POP;
              end
            end
          end else if (cmp_le) begin
            // next frame is late enough: drop the held one and take it
            res_tag <= rd_data.tag;
            res_pts <= rd_data.pts;
            keep    <= pos;
            if ((pos + CW'(1)) < count) begin
              pos   <= pos + CW'(1);
              state <= ST_DEQ_RD;
            end else begin
              state <= ST_DEQ_POP;
            end
          end else begin
            state <= ST_DEQ_POP;
          end
        end
        ST_DEQ_POP: begin
          head     <= head_next;
          count    <= count - CW'(removed);
          res_drop <= drop_sat;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          // hand over the result when the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, res_drop, res_pts, res_tag, res_got, res_acc};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: verif/pts_frame_queue_with_drop_unit_tb.sv
// ----------------------------------------------------------------------------
// pts_frame_queue_with_drop_unit_tb: self-checking bench for the frame queue
// Drives enqueue and dequeue requests over the request stream, keeps its own
// sorted copy of the queue to work out each result, and compares every result
// field by field. Runs a directed opening, then random traffic built around a
// moving play time under several capacity and drop tolerance settings, with
// random idling on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_frame_queue_with_drop_unit_tb;
  import pfq_pkg::*;

  localparam int                 HALF_PERIOD = 6;
  localparam int                 STALL_LIMIT = 5000;
  localparam int                 SETTLE_CYCLES = 40;
  localparam int                 PHASES = 8;
  localparam int                 PHASE_ITEMS = 150;
  localparam logic [PTS_W-1:0]   PTS_MAX = 63'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [PTS_W-1:0]   PTS_MIN = 63'h4000_0000_0000_0000;
  localparam longint             TIME_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint             TIME_MIN = -64'sh4000_0000_0000_0000;

  // request tdata, lowest field last
  typedef struct packed {
    logic [1:0]       pad;
    logic [PTS_W-1:0] now;
    logic [PTS_W-1:0] pts;
    logic [TAG_W-1:0] tag;
  } request_t;

  // result tdata, lowest field last
  typedef struct packed {
    logic [2:0]        pad;
    logic [DROP_W-1:0] drops;
    logic [PTS_W-1:0]  pts;
    logic [TAG_W-1:0]  tag;
    logic              got;
    logic              acc;
  } result_t;

  // Sorted frame queue with its registers and the results still owed
  class presentation_queue;
    longint            frame_times[$];
    logic [TAG_W-1:0]  frame_tags[$];
    result_t           due_results[$];
    logic [CAP_W-1:0]  capacity;
    logic [TOL_W-1:0]  tolerance;
    int                mismatch_count;

    function new();
      capacity = CAP_RESET;
      tolerance = TOL_RESET;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
      if (idx == REG_CAPACITY) begin
        capacity = val[CAP_W-1:0];
      end else begin
        tolerance = val[TOL_W-1:0];
      end
    endfunction

    // Apply one accepted request and queue the result it owes
    function void note_request(logic cmd, request_t req);
      result_t res;
      int      lim;
      int      pos;
      int      keep;
      longint  stamp;
      longint  now_v;
      res = '0;
      lim = (capacity < DEPTH_DEF) ? int'(capacity) : DEPTH_DEF;
      if (cmd == CMD_ENQ) begin
        // insert behind every frame with a timestamp not later
        if (frame_times.size() < lim) begin
          stamp = longint'($signed(req.pts));
          pos = 0;
          while (pos < frame_times.size() && frame_times[pos] <= stamp) pos++;
          frame_times.insert(pos, stamp);
          frame_tags.insert(pos, req.tag);
          res.acc = 1'b1;
        end
      end else begin
        now_v = longint'($signed(req.now));
        if (frame_times.size() != 0 && frame_times[0] <= now_v) begin
          // skip ahead while the next frame is late beyond the tolerance
          keep = 0;
          while (keep + 1 < frame_times.size() &&
                 frame_times[keep + 1] + longint'(tolerance) <= now_v) keep++;
          res.got = 1'b1;
          res.tag = frame_tags[keep];
          res.pts = PTS_W'(frame_times[keep]);
          res.drops = (keep > int'(DROP_MAX)) ? DROP_MAX : DROP_W'(keep);
          repeat (keep + 1) begin
            void'(frame_times.pop_front());
            void'(frame_tags.pop_front());
          end
        end
      end
      due_results.push_back(res);
    endfunction

    task report(string what);
      $display("ERROR: %s", what);
      mismatch_count++;
    endtask

    // Compare one accepted result with the oldest one owed
    task check_result(result_t res);
      result_t want;
      if (due_results.size() == 0) begin
        report("result arrived with none outstanding");
        return;
      end
      want = due_results.pop_front();
      if (res.acc !== want.acc)
        report($sformatf("accepted %b, want %b", res.acc, want.acc));
      if (res.got !== want.got)
        report($sformatf("got_frame %b, want %b", res.got, want.got));
      if (res.tag !== want.tag)
        report($sformatf("out_tag %h, want %h", res.tag, want.tag));
      if (res.pts !== want.pts)
        report($sformatf("out_pts %0d, want %0d", $signed(res.pts), $signed(want.pts)));
      if (res.drops !== want.drops)
        report($sformatf("dropped_count %0d, want %0d", res.drops, want.drops));
    endtask

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [S_DW-1:0]   s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [M_DW-1:0]   m_axis_tdata;

  presentation_queue queue_model = new();
  int unsigned       send_idle = 33;
  int unsigned       recv_idle = 59;
  int                stall_cycles = 0;
  longint            play_time = 0;
  logic [TOL_W-1:0]  cur_tol = TOL_RESET;

  pts_frame_queue_with_drop_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Stall the result stream at random and check each accepted result
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      queue_model.check_result(result_t'(m_axis_tdata));
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Abort when nothing moves on either stream for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [PTS_W-1:0] rand_time();
    return PTS_W'({$urandom, $urandom});
  endfunction

  // Offer one request, idling first at random, and hold it until taken
  task automatic send_request(input logic cmd, input logic [TAG_W-1:0] tag,
                              input logic [PTS_W-1:0] pts,
                              input logic [PTS_W-1:0] now);
    request_t req;
    req = '{pad: '0, now: now, pts: pts, tag: tag};
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= req;
    do @(posedge clk); while (!s_axis_tready);
    queue_model.note_request(cmd, req);
  endtask

  // Stop sending, wait for every owed result, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (queue_model.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    queue_model.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly frames near a moving play time, some noise and time jumps
  task automatic send_random();
    int unsigned roll;
    longint      scale;
    scale = (cur_tol == 0) ? 1000 : longint'(cur_tol);
    roll = $urandom_range(99);
    if (roll < 8) begin
      send_request(1'($urandom_range(1)), TAG_W'($urandom), rand_time(), rand_time());
    end else if (roll < 11) begin
      case ($urandom_range(2))
        0: play_time = TIME_MIN;
        1: play_time = TIME_MAX - 4 * scale;
        default: play_time = longint'($signed(rand_time()));
      endcase
    end else if (roll < 61) begin
      send_request(CMD_ENQ, TAG_W'($urandom),
                   PTS_W'(play_time + (longint'($urandom_range(1000)) - 300) * scale / 200),
                   rand_time());
    end else begin
      send_request(CMD_DEQ, TAG_W'($urandom), rand_time(), PTS_W'(play_time));
      play_time = longint'($urandom_range(300)) * scale / 200 + play_time;
      if (play_time > TIME_MAX) play_time = TIME_MIN;
    end
  endtask

  initial begin
    logic [CAP_W-1:0] cap;
    logic [TOL_W-1:0] tol;
    int               sent;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed opening under reset settings
    send_request(CMD_DEQ, 16'hFFFF, PTS_MAX, 63'd0);
    send_request(CMD_ENQ, 16'hFFFF, PTS_MAX, PTS_MAX);
    send_request(CMD_ENQ, 16'h0000, PTS_MIN, PTS_MIN);
    send_request(CMD_ENQ, 16'h1111, 63'd0, rand_time());
    // equal timestamps leave in arrival order
    send_request(CMD_ENQ, 16'h2222, 63'd0, rand_time());
    // threshold below the range: no drop at the lowest time
    send_request(CMD_DEQ, 16'h0000, PTS_MIN, PTS_MIN);
    send_request(CMD_DEQ, 16'hA5A5, rand_time(), {PTS_W{1'b1}});
    send_request(CMD_DEQ, 16'h5A5A, rand_time(), 63'd0);
    send_request(CMD_DEQ, 16'h5A5A, rand_time(), 63'd0);
    for (int i = 0; i < 10; i++) begin
      send_request(CMD_ENQ, TAG_W'(16'h0010 + i), PTS_W'(100 * i), rand_time());
    end
    // drop every late frame but the last before the far one
    send_request(CMD_DEQ, 16'h0000, rand_time(), PTS_MAX);
    send_request(CMD_DEQ, 16'h0000, rand_time(), PTS_MAX);

    for (int phase = 0; phase < PHASES; phase++) begin
      // Rotate idling: heavier on the receiver, then on the sender, then none
      case (phase % 3)
        0: begin send_idle = 33; recv_idle = 59; end
        1: begin send_idle = 59; recv_idle = 33; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (phase > 0) begin
        drain();
        case (phase)
          1: begin cap = 5'd1;  tol = 32'd0; end
          2: begin cap = 5'd16; tol = 32'hFFFF_FFFF; end
          3: begin cap = 5'd0;  tol = 32'd1000; end
          4: begin cap = 5'd31; tol = 32'd50; end
          5: begin cap = CAP_W'($urandom_range(15, 2)); tol = $urandom; end
          6: begin cap = 5'd16; tol = TOL_W'($urandom_range(65535)); end
          default: begin cap = 5'd3; tol = 32'd1000000; end
        endcase
        write_reg(REG_CAPACITY, CFG_DW'(cap));
        write_reg(REG_DROP_TOL, tol);
        cur_tol = tol;
        play_time = 0;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_random();
        sent++;
      end
    end

    drain();
    if (queue_model.outstanding() != 0) queue_model.report("results still outstanding");
    if (queue_model.mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/pfq_pkg.sv
hw/rtl/pts_frame_queue_with_drop_unit.sv
verif/pts_frame_queue_with_drop_unit_tb.sv
